// ===== hdl/assert_macros.svh =====
// assertion macros shared by the checker modules
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SRMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srmf assertion failed");

// consequent checked in the cycle after the antecedent
`define SRMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srmf assertion failed");

`endif

// ===== hdl/srmf_pkg.sv =====
package srmf_pkg;

  // window depth
  localparam int WINDOW_LEN = 10;

  // slot index and fill count widths
  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  // field widths
  localparam int SAMPLE_W = 15;
  localparam int THRESH_W = 14;
  localparam int TDATA_W  = 16;

  // threshold after reset, 80 cm in 1/64 cm
  localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd5120;

endpackage

// ===== hdl/spike_reject_median_filter.sv =====
// spike words: shown in the cycle after acceptance; other words: the rank unit tests
//   one window slot per cycle (at most WINDOW_LEN slots) until it finds the median
// flow: one word in flight, as the single rank-count unit and the one-word-at-a-time
//   sequencer take no new word until the result word is taken
// reset: rst_ni async active low; empties the window, threshold back to 5120 (80 cm)
module spike_reject_median_filter
  import srmf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // threshold register write
  input  logic                cfg_wr_en_i,
  input  logic [THRESH_W-1:0] cfg_wr_data_i,
  // input word
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [TDATA_W-1:0]  s_axis_tdata_i,   // [14:0] sample_distance, [15] zero
  // result word
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [TDATA_W-1:0]  m_axis_tdata_o,   // [14:0] filtered_distance, [15] zero
  output logic                m_axis_tuser_o    // [0] spike_held
);

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RANK = 3'b010,
    ST_SEND = 3'b100
  } state_e;

  state_e state_q, state_d;

  // threshold register
  logic [THRESH_W-1:0] thresh_q;

  // ring of samples, slots 0..fill-1 are the only ones ever read
  logic signed [SAMPLE_W-1:0] win_q [WINDOW_LEN];
  logic [CNT_W-1:0]           fill_q;
  logic [IDX_W-1:0]           newest_q;
  logic signed [SAMPLE_W-1:0] last_q;     // copy of the newest sample

  // rank unit candidate
  logic [IDX_W-1:0]           cand_idx_q;
  logic signed [SAMPLE_W-1:0] cand;
  logic [CNT_W-1:0]           rank_cnt;
  logic                       rank_hit;

  // result register
  logic signed [SAMPLE_W-1:0] res_dist_q;
  logic                       res_spike_q;

  // input side
  logic                       in_fire;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag;
  logic                       spike;
  logic [IDX_W-1:0]           wr_slot;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign sample  = s_axis_tdata_i[SAMPLE_W-1:0];

  // jump from the previous sample, one bit wider so it cannot overflow
  assign diff  = {sample[SAMPLE_W-1], sample} - {last_q[SAMPLE_W-1], last_q};
  assign mag   = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
  assign spike = (fill_q != '0) &&
                 (mag > {{(SAMPLE_W + 1 - THRESH_W){1'b0}}, thresh_q});

  // first sample goes to slot 0, then the slot after the newest with wrap
  always_comb begin
    if (fill_q == '0) begin
      wr_slot = '0;
    end else if (newest_q == IDX_W'(WINDOW_LEN - 1)) begin
      wr_slot = '0;
    end else begin
      wr_slot = newest_q + 1'b1;
    end
  end

  // rank unit: number of held samples that sort ahead of the candidate,
  // ties broken by slot order so every slot has a distinct rank
  assign cand = win_q[cand_idx_q];

  always_comb begin
    rank_cnt = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if ((j < int'(fill_q)) &&
          ((win_q[j] < cand) || ((win_q[j] == cand) && (j < int'(cand_idx_q))))) begin
        rank_cnt = rank_cnt + CNT_W'(1);
      end
    end
  end

  // upper median sits at rank count/2
  assign rank_hit = (rank_cnt == (fill_q >> 1));

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = spike ? ST_SEND : ST_RANK;
        end
      end
      ST_RANK: begin
        if (rank_hit) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      thresh_q <= THRESH_RESET;
      fill_q   <= '0;
      newest_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        thresh_q <= cfg_wr_data_i;
      end
      if (in_fire) begin
        newest_q <= wr_slot;
        if (fill_q != CNT_W'(WINDOW_LEN)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // window, candidate and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_q[wr_slot] <= sample;
      last_q         <= sample;
      cand_idx_q     <= '0;
      // a spike returns the previous sample unchanged
      res_dist_q     <= last_q;
      res_spike_q    <= spike;
    end else if (state_q == ST_RANK) begin
      if (rank_hit) begin
        res_dist_q <= cand;
      end else begin
        cand_idx_q <= cand_idx_q + 1'b1;
      end
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_SEND);
  assign m_axis_tdata_o  = {{(TDATA_W - SAMPLE_W){1'b0}}, res_dist_q};
  assign m_axis_tuser_o  = res_spike_q;

endmodule

// ===== hdl/srmf_checker.sv =====
`include "assert_macros.svh"

module srmf_checker
  import srmf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tuser_o
);

  // a stalled result word holds
  `SRMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // one word in flight: never ready for input while a result is shown
  `SRMF_ASSERT_NOW(a_one_in_flight, 1'b1, !(s_axis_tready_o && m_axis_tvalid_o))

  // busy right after taking a word
  `SRMF_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // at most one result per word: valid drops right after a result is taken
  `SRMF_ASSERT_NEXT(a_one_result, m_axis_tvalid_o && m_axis_tready_i, !m_axis_tvalid_o)

endmodule

bind spike_reject_median_filter srmf_checker u_srmf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/sv/spike_reject_median_filter_checker.sv =====
`timescale 1ns / 100ps

module spike_reject_median_filter_checker
  import srmf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [THRESH_W-1:0] cfg_wr_data_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [TDATA_W-1:0]  s_axis_tdata_i,   // [14:0] sample_distance, [15] zero
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [TDATA_W-1:0]  m_axis_tdata_i,   // [14:0] filtered_distance, [15] zero
  input  logic                m_axis_tuser_i,   // [0] spike_held
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int REPORT_MAX = 10;
  // predicted words in flight, far more than the block can hold
  localparam int WANT_DEPTH = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] distance;
    logic                       spike;
  } filt_word_t;

  // own copy of the window ring and threshold
  logic signed [SAMPLE_W-1:0] win_q [WINDOW_LEN];
  int                         fill_q;
  int                         newest_q;
  logic [THRESH_W-1:0]        thresh_q;
  filt_word_t                 want_fifo [WANT_DEPTH];
  int                         want_wr;
  int                         want_rd;

  function automatic logic signed [SAMPLE_W-1:0] window_median();
    logic signed [SAMPLE_W-1:0] sorted [WINDOW_LEN];
    logic signed [SAMPLE_W-1:0] key;
    int                         j;
    for (int i = 0; i < fill_q; i++) sorted[i] = win_q[i];
    for (int i = 1; i < fill_q; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    // upper median for an even count
    return sorted[fill_q / 2];
  endfunction

  function automatic void store_in_window(logic signed [SAMPLE_W-1:0] s);
    newest_q = (fill_q == 0) ? 0 : (newest_q + 1) % WINDOW_LEN;
    win_q[newest_q] = s;
    if (fill_q < WINDOW_LEN) fill_q++;
  endfunction

  function automatic filt_word_t filter_sample(logic signed [SAMPLE_W-1:0] s);
    filt_word_t                 w;
    logic signed [SAMPLE_W-1:0] prev;
    int                         jump;
    prev = win_q[newest_q];
    jump = int'(s) - int'(prev);
    if (jump < 0) jump = -jump;
    store_in_window(s);
    if (fill_q > 1 && jump > int'(thresh_q)) begin
      // spike: hold the previous sample
      w.distance = prev;
      w.spike    = 1'b1;
    end else begin
      w.distance = window_median();
      w.spike    = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) win_q[i] = '0;
      fill_q       = 0;
      newest_q     = 0;
      thresh_q     = THRESH_RESET;
      fail_count_o = 0;
      pending_o    = 0;
      want_wr      = 0;
      want_rd      = 0;
    end else begin
      // results first, a word accepted this edge cannot answer itself
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (want_wr == want_rd) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: unexpected result word dist=%0d spike=%0b", $realtime,
                     $signed(m_axis_tdata_i[SAMPLE_W-1:0]), m_axis_tuser_i);
          fail_count_o++;
        end else begin
          want = want_fifo[want_rd % WANT_DEPTH];
          want_rd++;
          if (m_axis_tdata_i[SAMPLE_W-1:0] !== want.distance ||
              m_axis_tuser_i !== want.spike) begin
            if (fail_count_o < REPORT_MAX)
              $display("%0t: result mismatch: expected dist=%0d spike=%0b, got dist=%0d spike=%0b",
                       $realtime, want.distance, want.spike,
                       $signed(m_axis_tdata_i[SAMPLE_W-1:0]), m_axis_tuser_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_wr_en_i) thresh_q = cfg_wr_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (want_wr - want_rd == WANT_DEPTH) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: too many words in flight", $realtime);
          fail_count_o++;
          want_rd++;
        end
        want_fifo[want_wr % WANT_DEPTH] = filter_sample(s_axis_tdata_i[SAMPLE_W-1:0]);
        want_wr++;
      end
      pending_o = want_wr - want_rd;
    end
  end

endmodule

// ===== tb/sv/spike_reject_median_filter_test.sv =====
`timescale 1ns / 100ps

module spike_reject_median_filter_test;
  import srmf_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  // no handshake for this long means the block is stuck
  localparam int STUCK_LIMIT  = 5000;
  // settle time after the last result, well above the longest time one word can take
  localparam int DRAIN_CYCLES = 2 * WINDOW_LEN + 10;
  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_ITEMS  = 140;
  localparam int DIR_N        = 22;
  // long receiver hold-off, started 40 words into the last phase
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = DIR_N + 5 * PHASE_ITEMS + 40;
  localparam int DIST_MIN     = -64;
  localparam int DIST_MAX     = 9600;
  localparam int JUMP_MAX     = 9664;

  // directed words, each commented with its jump against the one before
  localparam int DIRECTED [DIR_N] = '{
    0,        // first sample after reset, no spike test
    5120,     // jump equal to the reset threshold, accepted
    10241,    // one above the threshold upward, spike
    5121,     // threshold exactly downward, accepted
    0,        // one above the threshold downward, spike
    -64,      // error code as an ordinary sample
    9600,     // full range jump from the error code, spike
    9600,     // repeat
    16383,    // largest positive word, spike
    16383,
    -16384,   // most negative word, widest jump, spike; first wrap of the ring
    -16384,   // repeat, window full
    -64,      // ring keeps wrapping from here on
    100,
    200,
    300,
    -1,
    4800,
    4700,
    4600,
    10922,    // alternating bit patterns
    -10923
  };

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_wr_en    = 1'b0;
  logic [THRESH_W-1:0] cfg_wr_data  = '0;
  logic                s_tvalid     = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata      = '0;
  logic                m_tvalid;
  logic                m_tready     = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tuser;

  int fail_count;
  int pending;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stuck_cycles = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  spike_reject_median_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  spike_reject_median_filter_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // offer one sample word, maybe after an idle gap, and return at its acceptance edge
  // tvalid stays high on return so back-to-back words never drop it
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample_bits);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(TDATA_W-SAMPLE_W){1'b0}}, sample_bits};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // change the threshold only once every result word is back and the block is quiet
  task automatic set_threshold(input logic [THRESH_W-1:0] thr);
    s_tvalid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk_i);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver: random back-pressure, plus one long hold-off counted here
  initial begin : result_sink
    int taken;
    int hold_left;
    taken     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        taken++;
        if (taken == HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [THRESH_W-1:0] thr;
    int                  last_dist;
    int                  next_dist;
    int                  pick;
    int                  step;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words against the reset threshold, sender light and receiver heavy
    snd_idle_pct = 34;
    rcv_idle_pct = 86;
    for (int i = 0; i < DIR_N; i++) send_sample(DIRECTED[i][SAMPLE_W-1:0]);
    last_dist = DIRECTED[DIR_N-1];

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      // threshold sweep: zero, all ones, top of the range, random, one, reset value
      case (ph)
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = THRESH_W'(JUMP_MAX);
        3:       thr = THRESH_W'($urandom_range(0, (1 << THRESH_W) - 1));
        4:       thr = THRESH_W'(1);
        default: thr = THRESH_RESET;
      endcase
      set_threshold(thr);

      // idling: sender light and receiver heavy, then swapped, then none
      if (ph < 2) begin
        snd_idle_pct = 34;
        rcv_idle_pct = 86;
      end else if (ph < 4) begin
        snd_idle_pct = 86;
        rcv_idle_pct = 34;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // error code
          next_dist = DIST_MIN;
        end else if (pick < 18) begin
          // any 15-bit word, reaches every bit and the negative range
          next_dist = $urandom_range(0, (1 << SAMPLE_W) - 1);
        end else if (pick < 26) begin
          // right at the threshold or one past it, either direction
          step = int'(thr) + $urandom_range(0, 1);
          next_dist = $urandom_range(0, 1) ? last_dist + step : last_dist - step;
        end else begin
          if (pick < 36)      step = $urandom_range(0, 2 * JUMP_MAX) - JUMP_MAX;
          else if (pick < 42) step = 0;
          else                step = $urandom_range(0, 1200) - 600;
          // plausible distance track with small steps and occasional jumps
          next_dist = last_dist + step;
          if (next_dist < DIST_MIN) next_dist = DIST_MIN;
          if (next_dist > DIST_MAX) next_dist = DIST_MAX;
        end
        // the ring holds the word as sent, so track it at field width
        last_dist = int'($signed(next_dist[SAMPLE_W-1:0]));
        send_sample(next_dist[SAMPLE_W-1:0]);
      end
    end

    s_tvalid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
